// ===== rtl/icsdt_pkg.sv =====
// Shared types, constants and helpers for the iCalendar date/time parser.
// Used by the front end, the back end, the top level and the testbench.
package icsdt_pkg;

   // ASCII codes the parser looks for
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_T    = 8'h54;
   localparam logic [7:0] CHAR_Z    = 8'h5A;

   // Character positions inside a value
   localparam logic [7:0] POS_MONTH   = 8'd4;
   localparam logic [7:0] POS_DAY     = 8'd6;
   localparam logic [7:0] POS_SEP     = 8'd8;
   localparam logic [7:0] POS_MINUTE  = 8'd11;
   localparam logic [7:0] POS_END     = 8'd13;
   localparam logic [7:0] COUNT_MAX   = 8'd255;
   localparam logic [7:0] LEN_DATE    = 8'd8;
   localparam logic [7:0] LEN_DATETIME = 8'd13;

   localparam int MIN_PER_DAY = 24 * 60;
   localparam int OFFSET_W    = 12;

   // Register map
   localparam logic CSR_IDX_UTC_OFFSET = 1'b0;

   // Default depth of the queue between front and back
   localparam int FIFO_DEPTH_DEF = 4;

   // One finished value as collected by the front end
   typedef struct packed {
      logic [13:0] year;
      logic [6:0]  month;
      logic [6:0]  day;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [7:0]  len;
      logic        date_ok;
      logic        time_ok;
      logic        last_z;
      logic        dparam;
   } icsdt_rec_type;

   localparam int REC_W = $bits(icsdt_rec_type);

   // Calendar date carried through the day adjustment
   typedef struct packed {
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } icsdt_date_type;

   // Days in a month; out-of-range months read as 30
   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] n;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
         4'd2:                                         n = leap ? 5'd29 : 5'd28;
         default:                                      n = 5'd30;
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/icsdt_front.sv =====
// Front end: takes characters, accumulates digits and checks per position.
// Pushes one record into the queue on the last character. Uses icsdt_pkg.
module icsdt_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    acc_valid,
   input  logic [7:0]              char_code,
   input  logic                    end_of_value,
   input  logic                    date_param,
   output logic                    push,
   output icsdt_pkg::icsdt_rec_type push_rec
);

   logic [7:0]  count_ff, count_in;
   logic [13:0] year_ff, year_in;
   logic [6:0]  month_ff, month_in;
   logic [6:0]  day_ff, day_in;
   logic [6:0]  hour_ff, hour_in;
   logic [6:0]  minute_ff, minute_in;
   logic        date_ok_ff, date_ok_in;
   logic        time_ok_ff, time_ok_in;
   logic        last_z_ff, last_z_in;

   logic        dig;
   logic [3:0]  d;

   // Work out the state after this character
   always_comb begin
      dig        = (char_code >= icsdt_pkg::CHAR_ZERO) && (char_code <= icsdt_pkg::CHAR_NINE);
      d          = dig ? 4'(char_code - icsdt_pkg::CHAR_ZERO) : 4'd0;
      year_in    = year_ff;
      month_in   = month_ff;
      day_in     = day_ff;
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      date_ok_in = date_ok_ff;
      time_ok_in = time_ok_ff;
      if (count_ff < icsdt_pkg::POS_SEP) begin
         if (!dig) begin
            date_ok_in = 1'b0;
         end else if (count_ff < icsdt_pkg::POS_MONTH) begin
            year_in = year_ff * 14'd10 + 14'(d);
         end else if (count_ff < icsdt_pkg::POS_DAY) begin
            month_in = month_ff * 7'd10 + 7'(d);
         end else begin
            day_in = day_ff * 7'd10 + 7'(d);
         end
      end else if (count_ff == icsdt_pkg::POS_SEP) begin
         if (char_code != icsdt_pkg::CHAR_T) time_ok_in = 1'b0;
      end else if (count_ff < icsdt_pkg::POS_END) begin
         if (!dig) begin
            time_ok_in = 1'b0;
         end else if (count_ff < icsdt_pkg::POS_MINUTE) begin
            hour_in = hour_ff * 7'd10 + 7'(d);
         end else begin
            minute_in = minute_ff * 7'd10 + 7'(d);
         end
      end
      last_z_in = (char_code == icsdt_pkg::CHAR_Z);
      count_in  = (count_ff == icsdt_pkg::COUNT_MAX) ? count_ff : count_ff + 8'd1;
   end

   // Record of the whole value, including the last character
   always_comb begin
      push_rec.year    = year_in;
      push_rec.month   = month_in;
      push_rec.day     = day_in;
      push_rec.hour    = hour_in;
      push_rec.minute  = minute_in;
      push_rec.len     = count_in;
      push_rec.date_ok = date_ok_in;
      push_rec.time_ok = time_ok_in;
      push_rec.last_z  = last_z_in;
      push_rec.dparam  = date_param;
   end

   assign push = acc_valid && end_of_value;

   // Advance on every accepted character; clear after the last one
   always_ff @(posedge clock) begin
      if (reset || push) begin
         count_ff   <= '0;
         year_ff    <= '0;
         month_ff   <= '0;
         day_ff     <= '0;
         hour_ff    <= '0;
         minute_ff  <= '0;
         date_ok_ff <= 1'b1;
         time_ok_ff <= 1'b1;
         last_z_ff  <= 1'b0;
      end else if (acc_valid) begin
         count_ff   <= count_in;
         year_ff    <= year_in;
         month_ff   <= month_in;
         day_ff     <= day_in;
         hour_ff    <= hour_in;
         minute_ff  <= minute_in;
         date_ok_ff <= date_ok_in;
         time_ok_ff <= time_ok_in;
         last_z_ff  <= last_z_in;
      end
   end

endmodule

// ===== rtl/icsdt_fifo.sv =====
// Short register queue between the front end and the back end.
// Generic in width and depth; no package dependency.
module icsdt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   // Store an entry
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_ptr_ff] <= wr_data;
   end

   // Move pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (wr_en && !rd_en) begin
            count_ff <= count_ff + 1'b1;
         end else if (rd_en && !wr_en) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   wr_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (!full || rd_en))
      else $error("queue written while full");

   rd_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !empty)
      else $error("queue read while empty");

endmodule

// ===== rtl/icsdt_back.sv =====
// Back end: checks a collected value, applies the UTC offset to timed values ending in Z
// with day carry and holds the result for the output channel. Uses icsdt_pkg.
module icsdt_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rec_avail,
   input  icsdt_pkg::icsdt_rec_type rec,
   output logic                     pop,
   input  logic [icsdt_pkg::OFFSET_W-1:0] utc_offset,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [39:0]              rsp_tdata,
   output logic [1:0]               rsp_tuser
);

   localparam logic signed [14:0] DAY_S  = 15'sd1440;
   localparam logic signed [14:0] DAY2_S = 15'sd2880;

   logic adv;

   // Stage 1: quotient by 100 for the leap test, hours in minutes
   logic                     s1_vld_ff;
   icsdt_pkg::icsdt_rec_type s1_rec_ff;
   logic [7:0]               s1_q100_ff;
   logic [12:0]              s1_hm_ff;

   // Stage 2: checks and day shift
   logic                     s2_vld_ff;
   logic                     s2_ok_ff, s2_allday_ff, s2_leap_ff;
   logic                     s2_move_ff, s2_back_ff, s2_two_ff;
   icsdt_pkg::icsdt_date_type s2_date_ff;
   logic [10:0]              s2_tnorm_ff;

   // Stage 3: day carry, hour by reciprocal
   logic                     s3_vld_ff;
   logic                     s3_ok_ff, s3_allday_ff;
   icsdt_pkg::icsdt_date_type s3_date_ff;
   logic [10:0]              s3_tnorm_ff;
   logic [4:0]               s3_hour_ff;

   // Output register
   logic                     out_vld_ff;
   logic [39:0]              out_data_ff;
   logic [1:0]               out_user_ff;

   assign adv = !out_vld_ff || rsp_tready;
   assign pop = adv && rec_avail;

   // One day forward or backward
   function automatic icsdt_pkg::icsdt_date_type day_step(
      input icsdt_pkg::icsdt_date_type dt, input logic back, input logic leap);
      icsdt_pkg::icsdt_date_type r;
      r = dt;
      if (back) begin
         if (dt.day == 5'd1) begin
            if (dt.month == 4'd1) begin
               r.month = 4'd12;
               r.year  = dt.year - 16'd1;
            end else begin
               r.month = dt.month - 4'd1;
            end
            r.day = icsdt_pkg::month_len(r.month, leap);
         end else begin
            r.day = dt.day - 5'd1;
         end
      end else begin
         if (dt.day >= icsdt_pkg::month_len(dt.month, leap)) begin
            r.day = 5'd1;
            if (dt.month == 4'd12) begin
               r.month = 4'd1;
               r.year  = dt.year + 16'd1;
            end else begin
               r.month = dt.month + 4'd1;
            end
         end else begin
            r.day = dt.day + 5'd1;
         end
      end
      return r;
   endfunction

   // Stage 1
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_rec_ff  <= rec;
         s1_q100_ff <= 8'((27'(rec.year) * 27'd5243) >> 19);
         s1_hm_ff   <= 13'(rec.hour) * 13'd60;
      end
   end

   // Stage 2 logic
   logic [13:0]        r100;
   logic               leap;
   logic [4:0]         mlen;
   logic               date_good, time_good, allday, ok;
   logic signed [14:0] off_ext, total, tfix;
   logic               move, back, two;

   always_comb begin
      r100      = s1_rec_ff.year - (14'(s1_q100_ff) * 14'd100);
      leap      = (s1_rec_ff.year[1:0] == 2'b00) && ((r100 != '0) || (s1_q100_ff[1:0] == 2'b00));
      mlen      = icsdt_pkg::month_len(s1_rec_ff.month[3:0], leap);
      date_good = (s1_rec_ff.len >= icsdt_pkg::LEN_DATE) && s1_rec_ff.date_ok &&
                  (s1_rec_ff.month >= 7'd1) && (s1_rec_ff.month <= 7'd12) &&
                  (s1_rec_ff.day >= 7'd1) && (s1_rec_ff.day <= 7'(mlen));
      allday    = s1_rec_ff.dparam || (s1_rec_ff.len == icsdt_pkg::LEN_DATE);
      time_good = (s1_rec_ff.len >= icsdt_pkg::LEN_DATETIME) && s1_rec_ff.time_ok &&
                  (s1_rec_ff.hour <= 7'd23) && (s1_rec_ff.minute <= 7'd59);
      ok        = date_good && (allday || time_good);
      off_ext   = s1_rec_ff.last_z ? {{3{utc_offset[11]}}, utc_offset} : 15'sd0;
      total     = $signed({2'b00, s1_hm_ff}) + $signed({8'd0, s1_rec_ff.minute}) + off_ext;
      back      = (total < 15'sd0);
      two       = (total < -DAY_S) || (total >= DAY2_S);
      move      = back || (total >= DAY_S);
      if (two) begin
         tfix = back ? total + DAY2_S : total - DAY2_S;
      end else if (move) begin
         tfix = back ? total + DAY_S : total - DAY_S;
      end else begin
         tfix = total;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ok_ff         <= ok;
         s2_allday_ff     <= allday;
         s2_leap_ff       <= leap;
         s2_move_ff       <= move && !allday;
         s2_back_ff       <= back;
         s2_two_ff        <= two;
         s2_date_ff.year  <= 16'(s1_rec_ff.year);
         s2_date_ff.month <= s1_rec_ff.month[3:0];
         s2_date_ff.day   <= s1_rec_ff.day[4:0];
         s2_tnorm_ff      <= tfix[10:0];
      end
   end

   // Stage 3 logic: up to two chained day steps
   icsdt_pkg::icsdt_date_type step1, step2;
   logic [21:0]               hq_prod;

   always_comb begin
      step1   = s2_move_ff ? day_step(s2_date_ff, s2_back_ff, s2_leap_ff) : s2_date_ff;
      step2   = (s2_move_ff && s2_two_ff) ? day_step(step1, s2_back_ff, s2_leap_ff) : step1;
      hq_prod = 22'(s2_tnorm_ff) * 22'd1093;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_ok_ff     <= s2_ok_ff;
         s3_allday_ff <= s2_allday_ff;
         s3_date_ff   <= step2;
         s3_tnorm_ff  <= s2_tnorm_ff;
         s3_hour_ff   <= 5'(hq_prod >> 16);
      end
   end

   // Output stage: minute as remainder, zero the fields that do not apply
   logic [5:0] minute;
   logic [4:0] hour_o;
   logic [5:0] minute_o;

   always_comb begin
      minute   = 6'(s3_tnorm_ff - 11'(s3_hour_ff * 11'd60));
      hour_o   = s3_allday_ff ? 5'd0 : s3_hour_ff;
      minute_o = s3_allday_ff ? 6'd0 : minute;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (s3_ok_ff) begin
            out_data_ff <= {4'd0, minute_o, hour_o, s3_date_ff.day, s3_date_ff.month,
                            s3_date_ff.year};
            out_user_ff <= {s3_allday_ff, 1'b1};
         end else begin
            out_data_ff <= '0;
            out_user_ff <= '0;
         end
      end
   end

   // Valid bits of the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff  <= rec_avail;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         out_vld_ff <= s3_vld_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   bad_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0) && !rsp_tuser[1])
      else $error("rejected value carries nonzero fields");

   all_day_no_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (rsp_tdata[35:25] == '0))
      else $error("all-day value carries a time");

   good_value_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         (rsp_tdata[19:16] >= 4'd1) && (rsp_tdata[19:16] <= 4'd12) &&
         (rsp_tdata[24:20] != 5'd0) && (rsp_tdata[29:25] <= 5'd23) &&
         (rsp_tdata[35:30] <= 6'd59))
      else $error("accepted value out of range");

endmodule

// ===== rtl/ics_datetime_parser.sv =====
// iCalendar DATE / DATE-TIME parser, top level: stream ports, APB-style
// offset register, front end, queue and back end. Uses icsdt_pkg. After the last
// character is accepted, a value passes the queue, three back-end stages and the
// output register before rsp_tvalid rises. Throughput: one character and one
// result per cycle while nothing stalls; output stalls fill the FIFO_DEPTH-entry
// queue before req_tready drops. Reset: synchronous, clears control state.
module ics_datetime_parser #(
   parameter int FIFO_DEPTH = icsdt_pkg::FIFO_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // char stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // end_of_value
   input  logic [0:0]  req_tuser,   // [0] date_param
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] year_out, [19:16] month_out, [24:20] day_out,
                                    // [29:25] hour_out, [35:30] minute_out, [39:36] zero
   output logic [1:0]  rsp_tuser,   // [0] valid_res, [1] all_day
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [icsdt_pkg::OFFSET_W-1:0] offset_ff, offset_in;
   logic                           csr_wr;

   logic                     push, pop, q_full, q_empty;
   icsdt_pkg::icsdt_rec_type push_rec, pop_rec;

   // Offset register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == icsdt_pkg::CSR_IDX_UTC_OFFSET);
   assign offset_in  = csr_wr ? csr_pwdata[icsdt_pkg::OFFSET_W-1:0] : offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

   always_comb begin
      if (csr_paddr[2] == icsdt_pkg::CSR_IDX_UTC_OFFSET) begin
         csr_prdata = {{(32 - icsdt_pkg::OFFSET_W){offset_ff[icsdt_pkg::OFFSET_W-1]}},
                       offset_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   // Accept while the queue has room
   assign req_tready = !q_full;

   icsdt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .acc_valid    (req_tvalid && req_tready),
      .char_code    (req_tdata),
      .end_of_value (req_tlast),
      .date_param   (req_tuser[0]),
      .push         (push),
      .push_rec     (push_rec)
   );

   icsdt_fifo #(
      .WIDTH (icsdt_pkg::REC_W),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (push_rec),
      .rd_en   (pop),
      .rd_data (pop_rec),
      .full    (q_full),
      .empty   (q_empty)
   );

   icsdt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .rec_avail  (!q_empty),
      .rec        (pop_rec),
      .pop        (pop),
      .utc_offset (offset_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== verif/ics_datetime_parser_tb.sv =====
// Self-checking testbench for ics_datetime_parser: streams iCalendar date and date-time
// values one character per transaction and checks every parsed result against a predictor.
// Depends on icsdt_pkg and the ics_datetime_parser RTL only.
module ics_datetime_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 9;
   localparam int MAX_GAP         = 14;
   localparam int PIPE_SLACK      = 8;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int MAX_REPORTED    = 10;
   localparam int CHARS_PER_PHASE = 32;
   localparam int LONG_FILL       = 246;

   localparam logic [2:0] ADDR_UTC_OFFSET = {icsdt_pkg::CSR_IDX_UTC_OFFSET, 2'b00};

   // One parsed value as it leaves the block
   typedef struct packed {
      logic        valid;
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic        all_day;
   } parsed_date_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] char_code
   logic        req_tlast = 1'b0;
   logic [0:0]  req_tuser = '0;   // [0] date_param
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [15:0] year, [19:16] month, [24:20] day, [29:25] hour,
                                  // [35:30] minute, [39:36] zero
   logic [1:0]  rsp_tuser;        // [0] valid_res, [1] all_day
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predictor state, mirrors the parser between values
   logic [7:0]        seen_count    = '0;
   logic [13:0]       year_digits   = '0;
   logic [6:0]        month_digits  = '0;
   logic [6:0]        day_digits    = '0;
   logic [6:0]        hour_digits   = '0;
   logic [6:0]        minute_digits = '0;
   logic              date_form_ok  = 1'b1;
   logic              time_form_ok  = 1'b1;
   logic              ended_in_z    = 1'b0;
   logic signed [11:0] zulu_offset  = '0;

   parsed_date_type expected_dates[$];
   logic [7:0]      value_chars[$];

   int notable_years[8] = '{0, 1, 1900, 2000, 2023, 2024, 2100, 9999};

   int  mismatches      = 0;
   int  chars_sent      = 0;
   int  values_sent     = 0;
   int  results_checked = 0;
   int  valid_seen      = 0;
   int  all_day_seen    = 0;
   int  offset_writes   = 0;
   int  ready_hold      = 0;
   logic tx_steady      = 1'b0;
   logic rx_steady      = 1'b0;

   ics_datetime_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Calendar helpers for the predictor
   function automatic logic leap_year(input int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int days_in_month(input int y, input int m);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         2:                     return leap_year(y) ? 29 : 28;
         default:               return 30;
      endcase
   endfunction

   function automatic void flag_mismatch(input string what, input logic [39:0] want,
                                         input logic [39:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTED)
         $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
   endfunction

   // Advance the predictor by one accepted character; queue a result on the last one
   function automatic void parse_char(input logic [7:0] c, input logic last, input logic dparam);
      logic [7:0]      pos;
      logic            is_digit;
      int              digit, len, year, month, day, total;
      logic            ok, whole_day;
      parsed_date_type res;
      pos = seen_count;
      is_digit = (c >= icsdt_pkg::CHAR_ZERO) && (c <= icsdt_pkg::CHAR_NINE);
      digit = is_digit ? int'(c - icsdt_pkg::CHAR_ZERO) : 0;
      if (pos < icsdt_pkg::POS_SEP) begin
         if (!is_digit) date_form_ok = 1'b0;
         else if (pos < icsdt_pkg::POS_MONTH) year_digits = 14'(year_digits * 10 + digit);
         else if (pos < icsdt_pkg::POS_DAY) month_digits = 7'(month_digits * 10 + digit);
         else day_digits = 7'(day_digits * 10 + digit);
      end else if (pos == icsdt_pkg::POS_SEP) begin
         if (c != icsdt_pkg::CHAR_T) time_form_ok = 1'b0;
      end else if (pos < icsdt_pkg::POS_END) begin
         if (!is_digit) time_form_ok = 1'b0;
         else if (pos < icsdt_pkg::POS_MINUTE) hour_digits = 7'(hour_digits * 10 + digit);
         else minute_digits = 7'(minute_digits * 10 + digit);
      end
      ended_in_z = (c == icsdt_pkg::CHAR_Z);
      if (seen_count != icsdt_pkg::COUNT_MAX) seen_count++;
      if (!last) return;

      len = int'(seen_count);
      year = int'(year_digits);
      month = int'(month_digits);
      day = int'(day_digits);
      total = 0;
      whole_day = 1'b0;
      ok = (len >= icsdt_pkg::LEN_DATE) && date_form_ok && (month >= 1) && (month <= 12) &&
           (day >= 1) && (day <= days_in_month(year, month));
      if (ok) begin
         whole_day = dparam || (len == icsdt_pkg::LEN_DATE);
         if (!whole_day) begin
            ok = (len >= icsdt_pkg::LEN_DATETIME) && time_form_ok && (hour_digits <= 23) &&
                 (minute_digits <= 59);
            total = hour_digits * 60 + minute_digits;
            if (ok && ended_in_z) begin
               total += int'(zulu_offset);
               // carry whole days backward, then forward
               while (total < 0) begin
                  total += icsdt_pkg::MIN_PER_DAY;
                  day--;
                  if (day == 0) begin
                     month--;
                     if (month == 0) begin
                        month = 12;
                        year = (year - 1) & 16'hFFFF;
                     end
                     day = days_in_month(year, month);
                  end
               end
               while (total >= icsdt_pkg::MIN_PER_DAY) begin
                  total -= icsdt_pkg::MIN_PER_DAY;
                  day++;
                  if (day > days_in_month(year, month)) begin
                     day = 1;
                     month++;
                     if (month > 12) begin
                        month = 1;
                        year = (year + 1) & 16'hFFFF;
                     end
                  end
               end
            end
         end
      end

      res = '0;
      if (ok) begin
         res.valid   = 1'b1;
         res.year    = 16'(year);
         res.month   = 4'(month);
         res.day     = 5'(day);
         res.hour    = whole_day ? 5'd0 : 5'(total / 60);
         res.minute  = whole_day ? 6'd0 : 6'(total % 60);
         res.all_day = whole_day;
      end
      expected_dates = {expected_dates, res};

      // start over for the next value
      seen_count = '0;
      year_digits = '0;
      month_digits = '0;
      day_digits = '0;
      hour_digits = '0;
      minute_digits = '0;
      date_form_ok = 1'b1;
      time_form_ok = 1'b1;
      ended_in_z = 1'b0;
   endfunction

   // Add one character at the end of the value being built
   function automatic void append_char(input logic [7:0] c);
      value_chars = {value_chars, c};
   endfunction

   function automatic void load_text(input string s);
      value_chars.delete();
      foreach (s[i]) append_char(s[i]);
   endfunction

   // Mostly well-formed date-times with random content; some truncated, corrupted or noise
   function automatic void build_random_value(output logic dparam);
      int y, m, d, h, mi, dim, form, keep, n;
      y = ($urandom_range(0, 2) == 0) ? notable_years[$urandom_range(0, 7)]
                                      : $urandom_range(0, 9999);
      if ($urandom_range(0, 9) == 0) m = ($urandom_range(0, 1) == 1) ? $urandom_range(13, 99) : 0;
      else m = $urandom_range(1, 12);
      dim = days_in_month(y, m);
      case ($urandom_range(0, 9))
         0, 1, 2: d = dim;
         3, 4:    d = 1;
         5:       d = ($urandom_range(0, 1) == 1) ? $urandom_range(dim + 1, 99) : 0;
         default: d = $urandom_range(1, dim);
      endcase
      case ($urandom_range(0, 11))
         0:       h = 23;
         1:       h = 0;
         2:       h = $urandom_range(24, 99);
         default: h = $urandom_range(0, 23);
      endcase
      case ($urandom_range(0, 11))
         0:       mi = 59;
         1:       mi = 0;
         2:       mi = $urandom_range(60, 99);
         default: mi = $urandom_range(0, 59);
      endcase
      load_text($sformatf("%04d%02d%02dT%02d%02d", y, m, d, h, mi));
      dparam = ($urandom_range(0, 3) == 0);

      form = $urandom_range(0, 11);
      if (form == 0) keep = icsdt_pkg::LEN_DATE;
      else if (form == 9) keep = $urandom_range(1, 12);
      else keep = icsdt_pkg::LEN_DATETIME;
      if (value_chars.size() > keep) value_chars = value_chars[0:keep-1];
      case (form)
         2, 3, 4, 5, 6, 7: append_char(icsdt_pkg::CHAR_Z);
         8: begin
            // trailing characters past the minute, maybe ending in Z
            n = $urandom_range(1, 6);
            repeat (n) append_char(8'($urandom_range(32, 126)));
            if ($urandom_range(0, 1) == 1) append_char(icsdt_pkg::CHAR_Z);
         end
         10: begin
            value_chars.delete();
            n = $urandom_range(1, 16);
            repeat (n) append_char(8'($urandom_range(0, 255)));
         end
         11: begin
            append_char(icsdt_pkg::CHAR_Z);
            value_chars[$urandom_range(0, value_chars.size() - 1)] = 8'($urandom_range(0, 255));
         end
         default: ;
      endcase
   endfunction

   // Send one character transaction after a random gap unless tx_steady, then predict it
   task automatic send_char(input logic [7:0] c, input logic last, input logic dparam);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      req_tuser  <= dparam;
      do @(posedge clock); while (req_tready !== 1'b1);
      chars_sent++;
      parse_char(c, last, dparam);
   endtask

   // date_param only matters on the last character; randomize it elsewhere
   task automatic send_value(input logic dparam);
      foreach (value_chars[i])
         send_char(value_chars[i], i == value_chars.size() - 1,
                   (i == value_chars.size() - 1) ? dparam : 1'($urandom_range(0, 1)));
      values_sent++;
      if ($urandom_range(0, 4) == 0) tx_steady = !tx_steady;
   endtask

   // Drop valid, wait for every outstanding result, then let the pipeline empty
   task automatic settle_results();
      req_tvalid <= 1'b0;
      while (expected_dates.size() != 0) @(posedge clock);
      repeat (PIPE_SLACK) @(posedge clock);
   endtask

   // One register transaction; psel stays high until csr_release
   task automatic csr_access(input logic write, input logic [2:0] addr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      if (write && addr == ADDR_UTC_OFFSET) begin
         zulu_offset = wdata[11:0];
         offset_writes++;
      end
   endtask

   task automatic csr_release();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_offset(input int minutes);
      logic [31:0] unused_rd;
      csr_access(1'b1, ADDR_UTC_OFFSET, 32'(minutes), unused_rd);
      csr_release();
   endtask

   task automatic expect_offset_readback(input logic [11:0] want);
      logic [31:0] rd;
      csr_access(1'b0, ADDR_UTC_OFFSET, '0, rd);
      if (rd[11:0] !== want)
         flag_mismatch("utc_offset_minutes readback", 40'(want), 40'(rd[11:0]));
   endtask

   // Compare one result transaction with the oldest expectation
   task automatic check_result(input logic [39:0] data, input logic [1:0] user);
      parsed_date_type want;
      if (expected_dates.size() == 0) begin
         flag_mismatch("result with nothing outstanding, tdata", '0, data);
         return;
      end
      want = expected_dates.pop_front();
      results_checked++;
      if (want.valid) valid_seen++;
      if (want.all_day) all_day_seen++;
      if (user[0] !== want.valid)
         flag_mismatch("valid_res", 40'(want.valid), 40'(user[0]));
      if (data[15:0] !== want.year)
         flag_mismatch("year_out", 40'(want.year), 40'(data[15:0]));
      if (data[19:16] !== want.month)
         flag_mismatch("month_out", 40'(want.month), 40'(data[19:16]));
      if (data[24:20] !== want.day)
         flag_mismatch("day_out", 40'(want.day), 40'(data[24:20]));
      if (data[29:25] !== want.hour)
         flag_mismatch("hour_out", 40'(want.hour), 40'(data[29:25]));
      if (data[35:30] !== want.minute)
         flag_mismatch("minute_out", 40'(want.minute), 40'(data[35:30]));
      if (user[1] !== want.all_day)
         flag_mismatch("all_day", 40'(want.all_day), 40'(user[1]));
   endtask

   // Result side: check each transaction, stall ready for a drawn number of valid cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_hold = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         check_result(rsp_tdata, rsp_tuser);
         if ($urandom_range(0, 11) == 0) rx_steady = !rx_steady;
         ready_hold = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
         rsp_tready <= (ready_hold == 0);
      end else if (rsp_tvalid && !rsp_tready) begin
         if (ready_hold > 0) ready_hold--;
         rsp_tready <= (ready_hold == 0);
      end
   end

   // End the run when no transaction of any kind completes for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable && csr_pready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   // Reset value and both 12-bit extremes of the offset register
   task automatic test_offset_register();
      logic [31:0] unused_rd;
      expect_offset_readback(12'h000);
      csr_access(1'b1, ADDR_UTC_OFFSET, 32'h0000_07FF, unused_rd);
      expect_offset_readback(12'h7FF);
      csr_access(1'b1, ADDR_UTC_OFFSET, 32'hFFFF_F800, unused_rd);
      expect_offset_readback(12'h800);
      csr_release();
   endtask

   task automatic test_directed_values();
      write_offset(-1);
      // one minute back from the first of year zero wraps the year
      load_text("00000101T0000Z");
      send_value(1'b0);
      // exactly eight characters is a whole day; leap day
      load_text("20240229");
      send_value(1'b0);
      // too short to hold a date
      load_text("7");
      send_value(1'b1);
      settle_results();
   endtask

   // Length past the saturation point, still ending in Z
   task automatic test_saturating_length();
      write_offset(icsdt_pkg::MIN_PER_DAY);
      load_text("20241231T2300");
      repeat (LONG_FILL) append_char(8'($urandom_range(32, 126)));
      append_char(icsdt_pkg::CHAR_Z);
      send_value(1'b0);
      settle_results();
   endtask

   task automatic test_random_values(input int minutes);
      int   start_count;
      logic dparam;
      write_offset(minutes);
      start_count = chars_sent;
      while (chars_sent - start_count < CHARS_PER_PHASE) begin
         build_random_value(dparam);
         send_value(dparam);
      end
      settle_results();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_offset_register();
      test_directed_values();
      test_saturating_length();
      test_random_values(0);
      test_random_values(2047);
      test_random_values(-2048);
      test_random_values(icsdt_pkg::MIN_PER_DAY);
      test_random_values(-icsdt_pkg::MIN_PER_DAY);
      test_random_values(int'($urandom_range(0, 2 * icsdt_pkg::MIN_PER_DAY)) -
                         icsdt_pkg::MIN_PER_DAY);
      test_random_values(int'($urandom_range(0, 4095)) - 2048);
      if (expected_dates.size() != 0)
         flag_mismatch("results never delivered", '0, 40'(expected_dates.size()));
      $display("summary: %0d chars in %0d values, %0d results checked (%0d valid, %0d all-day)",
               chars_sent, values_sent, results_checked, valid_seen, all_day_seen);
      $display("summary: %0d offset writes, 12-bit extremes and one day either way included",
               offset_writes);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== ics_datetime_parser.f =====
rtl/icsdt_pkg.sv
rtl/icsdt_front.sv
rtl/icsdt_fifo.sv
rtl/icsdt_back.sv
rtl/ics_datetime_parser.sv
verif/ics_datetime_parser_tb.sv
